// ===== rtl/sat_pkg.sv =====
// Shared types and constants for the segment address translator.
// Holds the sequencer state type, the table entry layout and the field widths.
// No dependencies.
`default_nettype none

package sat_pkg;

    localparam int unsigned SEGMENT_SLOTS_DEFAULT = 16;
    localparam logic [31:0] MAX_SEG_SIZE_RESET    = 32'd64;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned SEG_ID_W    = 16;
    localparam int unsigned SLOT_IDX_W  = 4;
    localparam int unsigned DIV_CNT_W   = 5;
    localparam int unsigned S_TDATA_W   = 120;
    localparam int unsigned M_TDATA_W   = 40;

    // Item kinds carried on s_tuser.
    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SCAN,
        ST_RESPOND
    } sat_state_t;

    typedef struct packed {
        logic [SEG_ID_W-1:0] seg_id;
        logic [ADDR_W-1:0]   base;
        logic [ADDR_W-1:0]   length;
    } sat_entry_t;

endpackage

`default_nettype wire

// ===== rtl/segment_address_translator_top.sv =====
// Segment address translator, top level: segment table, shared divider and scan sequencer.
// Depends on sat_pkg for the state type, the table entry layout and the field widths.
// Flow: a translate item runs a bit-serial divide of logical_address by max_segment_size,
// then scans the table reading one slot per cycle; a zero divisor or a quotient above
// 16 bits skips straight to a faulting response. Throughput: one item at a time,
// loads back to back. Reset: synchronous, active low; clears valid bits, max size 64.
`default_nettype none

module segment_address_translator_top
    import sat_pkg::*;
#(
    parameter int unsigned SEGMENT_SLOTS = SEGMENT_SLOTS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // Configuration: max_segment_size.
    input  wire logic                 cfg_wr_en,
    input  wire logic [ADDR_W-1:0]    cfg_wr_data,

    // Input items.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata, lowest bit up: slot_index[3:0], entry_valid[4], segment_id[20:5],
    // segment_base[52:21], segment_length[84:53], logical_address[116:85], zero fill.
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: cmd (0 = load table slot, 1 = translate).
    input  wire logic                 s_tuser,

    // Result items.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata, lowest bit up: physical_address[31:0], xlat_fault[32], zero fill.
    output logic [M_TDATA_W-1:0]      m_tdata
);

    // Slot index width; a single-slot table still needs one address bit.
    localparam int unsigned SLOT_W = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SEGMENT_SLOTS - 1);

    // Unpacked input fields.
    logic [SLOT_IDX_W-1:0] in_slot_index;
    logic                  in_entry_valid;
    logic [SEG_ID_W-1:0]   in_segment_id;
    logic [ADDR_W-1:0]     in_segment_base;
    logic [ADDR_W-1:0]     in_segment_length;
    logic [ADDR_W-1:0]     in_logical_address;

    assign in_slot_index      = s_tdata[3:0];
    assign in_entry_valid     = s_tdata[4];
    assign in_segment_id      = s_tdata[20:5];
    assign in_segment_base    = s_tdata[52:21];
    assign in_segment_length  = s_tdata[84:53];
    assign in_logical_address = s_tdata[116:85];

    // Control state.
    sat_state_t             state_reg, state_next;
    logic [ADDR_W-1:0]      max_seg_reg;
    logic [SEGMENT_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SLOT_W-1:0]      scan_reg, scan_next;
    logic                   rd_pend_reg, rd_pend_next;

    // Datapath registers.
    logic [ADDR_W-1:0]      quo_reg, quo_next;
    logic [ADDR_W-1:0]      rem_reg, rem_next;
    logic                   rd_valid_reg;
    logic                   rd_last_reg;
    sat_entry_t             rd_entry_reg;
    logic [ADDR_W-1:0]      m_addr_reg, m_addr_next;
    logic                   m_fault_reg, m_fault_next;

    // Segment table storage.
    sat_entry_t             slot_mem [SEGMENT_SLOTS];

    logic                   s_accept;
    logic                   load_we;
    logic [SLOT_W-1:0]      wr_addr;
    sat_entry_t             wr_entry;

    // Divider step: shift the next dividend bit into the partial remainder and
    // subtract the divisor when it fits.
    logic [ADDR_W:0]        div_trial;
    logic [ADDR_W:0]        div_diff;
    logic                   div_fits;
    logic [ADDR_W-1:0]      div_rem_step;
    logic [ADDR_W-1:0]      div_quo_step;

    // Table match on the slot read in the previous cycle.
    logic                   rd_hit;
    logic                   rd_in_bounds;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_RESPOND);
    assign m_tdata  = {{(M_TDATA_W - ADDR_W - 1){1'b0}}, m_fault_reg, m_addr_reg};

    // A load whose slot lies beyond the table is dropped.
    assign load_we  = s_accept && (s_tuser == CMD_LOAD)
                      && (32'(in_slot_index) < 32'(SEGMENT_SLOTS));
    assign wr_addr  = SLOT_W'(in_slot_index);
    assign wr_entry = '{seg_id: in_segment_id, base: in_segment_base,
                        length: in_segment_length};

    assign div_trial    = {rem_reg, quo_reg[ADDR_W-1]};
    assign div_diff     = div_trial - {1'b0, max_seg_reg};
    assign div_fits     = !div_diff[ADDR_W];
    assign div_rem_step = div_fits ? div_diff[ADDR_W-1:0] : div_trial[ADDR_W-1:0];
    assign div_quo_step = {quo_reg[ADDR_W-2:0], div_fits};

    // The quotient's upper bits are known to be zero while scanning.
    assign rd_hit       = rd_valid_reg && (rd_entry_reg.seg_id == quo_reg[SEG_ID_W-1:0]);
    assign rd_in_bounds = (rem_reg < rd_entry_reg.length);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_tuser == CMD_TRANSLATE)) begin
                    state_next = (max_seg_reg == '0) ? ST_RESPOND : ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (cnt_reg == '0) begin
                    state_next = (div_quo_step[ADDR_W-1:SEG_ID_W] != '0) ? ST_RESPOND : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_pend_reg && (rd_hit || rd_last_reg)) begin
                    state_next = ST_RESPOND;
                end
            end
            ST_RESPOND: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and counters.
    always_comb begin
        slot_valid_next = slot_valid_reg;
        cnt_next        = cnt_reg;
        scan_next       = scan_reg;
        rd_pend_next    = 1'b0;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        m_addr_next     = m_addr_reg;
        m_fault_next    = m_fault_reg;

        if (load_we) begin
            slot_valid_next[wr_addr] = in_entry_valid;
        end

        case (state_reg)
            ST_IDLE: begin
                quo_next     = in_logical_address;
                rem_next     = '0;
                cnt_next     = '1;
                m_addr_next  = '0;
                m_fault_next = 1'b1;
            end
            ST_DIVIDE: begin
                quo_next  = div_quo_step;
                rem_next  = div_rem_step;
                cnt_next  = cnt_reg - DIV_CNT_W'(1);
                scan_next = '0;
            end
            ST_SCAN: begin
                // Read one slot per cycle; compare the slot read the cycle before.
                rd_pend_next = 1'b1;
                scan_next    = (scan_reg == LAST_SLOT) ? scan_reg : scan_reg + SLOT_W'(1);
                if (rd_pend_reg && rd_hit) begin
                    rd_pend_next = 1'b0;
                    if (rd_in_bounds) begin
                        m_addr_next  = rd_entry_reg.base + rem_reg;
                        m_fault_next = 1'b0;
                    end
                end else if (rd_pend_reg && rd_last_reg) begin
                    rd_pend_next = 1'b0;
                end
            end
            ST_RESPOND: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            max_seg_reg    <= MAX_SEG_SIZE_RESET;
            slot_valid_reg <= '0;
            cnt_reg        <= '0;
            scan_reg       <= '0;
            rd_pend_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            cnt_reg        <= cnt_next;
            scan_reg       <= scan_next;
            rd_pend_reg    <= rd_pend_next;
            if (cfg_wr_en) begin
                max_seg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_next_hold: begin
            quo_reg     <= quo_next;
            rem_reg     <= rem_next;
            m_addr_reg  <= m_addr_next;
            m_fault_reg <= m_fault_next;
        end
    end

    // Segment table: one write port for loads, one registered read port for the scan.
    always_ff @(posedge aclk) begin
        if (load_we) begin
            slot_mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= slot_mem[scan_reg];
        rd_valid_reg <= slot_valid_reg[scan_reg];
        rd_last_reg  <= (scan_reg == LAST_SLOT);
    end

endmodule

`default_nettype wire
